### src/b96su_pkg.sv
// Shared constants and controller/datapath interface types for the base-96 string unpacker.
`timescale 1ns / 1ps

package b96su_pkg;

  // Field widths of one input item and one result item.
  localparam int unsigned WordW   = 64;
  localparam int unsigned BufLenW = 8;
  localparam int unsigned CharW   = 7;
  localparam int unsigned CountW  = 4;

  // Packed word layout: character count on top, base-96 value below.
  localparam int unsigned ValW      = 56;
  localparam int unsigned CountLsb  = 56;
  localparam int unsigned CountFldW = 8;

  // Default for the largest character count the block honors.
  localparam int unsigned MaxCharsDef = 8;

  // A digit is 96 = 3 * 32: five low bits pass straight through, the rest is divided by 3.
  localparam int unsigned LowW      = 5;
  localparam int unsigned RemW      = 2;
  localparam logic [RemW:0] Divisor = 3'd3;

  // The divide-by-3 unit consumes this many dividend bits per cycle.
  localparam int unsigned DivChunk = 8;
  localparam int unsigned DivSteps = ValW / DivChunk;
  localparam int unsigned StepW    = $clog2(DivSteps);

  // ASCII offset added to each digit.
  localparam logic [CharW-1:0] CharOffset = 7'd32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture an accepted item
    logic prep;         // split off the low five bits of the next digit
    logic div_step;     // one chunk of the divide-by-3
    logic emit;         // load the next character into the output register
    logic emit_reject;  // load the single result of a rejected word
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;     // the word on the input port cannot be decoded
    logic div_last;   // the current divide step is the final one for this digit
    logic dig_last;   // the digit being extracted is the last one
    logic emit_last;  // the character being emitted is the last one
  } status_t;

endpackage

### src/b96su_datapath.sv
// Datapath: value register, serial divide-by-96 unit, digit store and output payload registers.
`timescale 1ns / 1ps

module b96su_datapath import b96su_pkg::*; #(
  parameter int unsigned MaxChars = MaxCharsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic [WordW-1:0]    packed_word_i,
  input  logic [BufLenW-1:0]  buf_len_i,
  output logic [CharW-1:0]    out_char_o,
  output logic                char_valid_o,
  output logic                is_last_o,
  output logic [CountW-1:0]   decoded_count_o
);

  localparam int unsigned IdxW = (MaxChars > 1) ? $clog2(MaxChars) : 1;

  // Control counters.
  logic [CountW-1:0] n_q, n_d;
  logic [CountW-1:0] k_q, k_d;
  logic [CountW-1:0] e_q, e_d;
  logic [StepW-1:0]  step_q, step_d;

  // Payload registers.
  logic [ValW-1:0]   div_q;
  logic [RemW-1:0]   rem_q;
  logic [LowW-1:0]   low_q;
  logic [CharW-1:0]  digit_store_q [MaxChars];
  logic [CharW-1:0]  out_char_q;
  logic              char_valid_q;
  logic              is_last_q;
  logic [CountW-1:0] decoded_count_q;

  logic [CountFldW-1:0] in_count;
  logic [ValW-1:0]      div_d;
  logic [RemW-1:0]      rem_d;
  logic [CountW-1:0]    wr_pos;
  logic [CharW-1:0]     rd_digit;

  // Word check on the input port.
  assign in_count = packed_word_i[CountLsb +: CountFldW];
  assign status_o.reject = (in_count == '0) ||
                           (in_count > CountFldW'(MaxChars)) ||
                           (in_count >= buf_len_i);

  assign status_o.div_last  = (step_q == StepW'(DivSteps - 1));
  assign status_o.dig_last  = (k_q == CountW'(n_q - 4'd1));
  assign status_o.emit_last = (e_q == CountW'(n_q - 4'd1));

  // One chunk of restoring division by 3, most significant bit first.
  always_comb begin
    logic [RemW-1:0] r;
    logic [RemW:0]   t;
    logic [DivChunk-1:0] qbits;
    r = rem_q;
    qbits = '0;
    for (int i = 0; i < DivChunk; i++) begin
      t = {r, div_q[ValW-1-i]};
      if (t >= Divisor) begin
        qbits[DivChunk-1-i] = 1'b1;
        r = RemW'(t - Divisor);
      end else begin
        r = t[RemW-1:0];
      end
    end
    div_d = {div_q[ValW-DivChunk-1:0], qbits};
    rem_d = r;
  end

  // Digits are found least significant first and stored from the top position down.
  assign wr_pos   = CountW'(n_q - k_q - 4'd1);
  assign rd_digit = digit_store_q[e_q[IdxW-1:0]];

  // Counter next values.
  always_comb begin
    n_d    = n_q;
    k_d    = k_q;
    e_d    = e_q;
    step_d = step_q;
    if (cmd_i.load) begin
      n_d = status_o.reject ? '0 : in_count[CountW-1:0];
      k_d = '0;
      e_d = '0;
    end
    if (cmd_i.prep) begin
      step_d = '0;
    end
    if (cmd_i.div_step) begin
      step_d = StepW'(step_q + 1'b1);
      if (status_o.div_last) begin
        k_d = CountW'(k_q + 4'd1);
      end
    end
    if (cmd_i.emit) begin
      e_d = CountW'(e_q + 4'd1);
    end
  end

  // Control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      k_q    <= '0;
      e_q    <= '0;
      step_q <= '0;
    end else begin
      n_q    <= n_d;
      k_q    <= k_d;
      e_q    <= e_d;
      step_q <= step_d;
    end
  end

  // Value register and divide unit state.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      div_q <= packed_word_i[ValW-1:0];
    end else if (cmd_i.prep) begin
      low_q <= div_q[LowW-1:0];
      div_q <= {{LowW{1'b0}}, div_q[ValW-1:LowW]};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
  end

  // Digit store: the remainder by 96 is the remainder by 3 above the five low bits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && status_o.div_last) begin
      digit_store_q[wr_pos[IdxW-1:0]] <= {rem_d, low_q};
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_q      <= CharW'(rd_digit + CharOffset);
      char_valid_q    <= 1'b1;
      is_last_q       <= status_o.emit_last;
      decoded_count_q <= status_o.emit_last ? n_q : '0;
    end else if (cmd_i.emit_reject) begin
      out_char_q      <= '0;
      char_valid_q    <= 1'b0;
      is_last_q       <= 1'b1;
      decoded_count_q <= '0;
    end
  end

  assign out_char_o      = out_char_q;
  assign char_valid_o    = char_valid_q;
  assign is_last_o       = is_last_q;
  assign decoded_count_o = decoded_count_q;

endmodule

### src/b96su_ctrl.sv
// Controller: sequences accept, digit extraction and emission, and owns the output valid flag.
`timescale 1ns / 1ps

module b96su_ctrl import b96su_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StDiv,
    StEmit,
    StReject
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // The output register can take a new item when empty or being drained.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  // Commands and next state.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = status_i.reject ? StReject : StPrep;
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = status_i.dig_last ? StEmit : StPrep;
        end
      end
      StEmit: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) begin
            state_d = StIdle;
          end
        end
      end
      StReject: begin
        if (slot_free) begin
          cmd_o.emit_reject = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output valid follows loads and drains of the output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit || cmd_o.emit_reject) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/base96_string_unpacker.sv
// Top level of the base-96 string unpacker: controller plus datapath.
`timescale 1ns / 1ps

// Each item is a 64-bit packed word (character count in bits 63..56, base-96
// value in bits 55..0) and the caller's buffer length. A word whose count is
// zero, above MAX_CHARS, or not below the buffer length gives one item with
// char_valid low, is_last high and a count of zero. Otherwise the block gives
// one item per character, most significant digit first, each digit plus 32;
// the top digit is taken modulo 96. Digits come from a serial divide-by-96
// unit: a prep step splits off the five low bits, then divide steps divide
// the rest by three, eight bits per cycle. A decoded word is accepted, all
// its digits are extracted, then its characters are emitted, one per cycle
// while the output is not stalled; a rejected word is accepted and then
// gives its single item. A new word is accepted while the last result still
// waits in the output register.
module base96_string_unpacker import b96su_pkg::*; #(
  parameter int unsigned MAX_CHARS = MaxCharsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [WordW-1:0]   packed_word_i,
  input  logic [BufLenW-1:0] buf_len_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CharW-1:0]   out_char_o,
  output logic               char_valid_o,
  output logic               is_last_o,
  output logic [CountW-1:0]  decoded_count_o
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  b96su_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Divide unit, digit store and output payload.
  b96su_datapath #(
    .MaxChars (MAX_CHARS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .packed_word_i   (packed_word_i),
    .buf_len_i       (buf_len_i),
    .out_char_o      (out_char_o),
    .char_valid_o    (char_valid_o),
    .is_last_o       (is_last_o),
    .decoded_count_o (decoded_count_o)
  );

endmodule

### src/b96su_checker.sv
// Port-level checker for the base-96 string unpacker and its bind statement.
`timescale 1ns / 1ps

module b96su_checker import b96su_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [CharW-1:0]   out_char_i,
  input logic               char_valid_i,
  input logic               is_last_i,
  input logic [CountW-1:0]  decoded_count_i
);

  // A stalled result item holds its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) &&
      $stable(char_valid_i) && $stable(is_last_i) && $stable(decoded_count_i))
    else $error("stalled result item changed");

  // A rejected word gives exactly one item with a zero character and count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !char_valid_i |->
      is_last_i && (out_char_i == '0) && (decoded_count_i == '0))
    else $error("malformed reject item");

  // Decoded characters are printable: the digit offset puts them at 32 or above.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && char_valid_i |-> (out_char_i >= CharOffset))
    else $error("decoded character below offset");

  // The count shows only on the final item of a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_last_i |-> (decoded_count_i == '0))
    else $error("count on a non-final item");

  // A decoded word's final item reports a count between one and eight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_last_i && char_valid_i |->
      (decoded_count_i != '0) && (decoded_count_i <= 4'd8))
    else $error("bad count on final item");

endmodule

bind base96_string_unpacker b96su_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .out_char_i      (out_char_o),
  .char_valid_i    (char_valid_o),
  .is_last_i       (is_last_o),
  .decoded_count_i (decoded_count_o)
);
